### src/sns_pkg.sv
// Shared types, codes and fixed-point constants for the spiking neuron step core.
package sns_pkg;

	// Number format: signed Q8.24 values.
	localparam int VALUE_W = 32;
	localparam int FRAC_W  = 24;
	localparam int PROD_W  = 2 * VALUE_W;
	localparam int MAG_W   = PROD_W - FRAC_W;

	localparam logic signed [VALUE_W-1:0] VMAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic signed [VALUE_W-1:0] VMIN = {1'b1, {(VALUE_W-1){1'b0}}};

	// FitzHugh-Nagumo constants a = -0.7 and b = 0.8, rounded to the fraction grid.
	localparam longint FHN_A_L = (-((longint'(7) << FRAC_W) + 5)) / 10;
	localparam longint FHN_B_L = ((longint'(8) << FRAC_W) + 5) / 10;
	localparam logic signed [VALUE_W-1:0] FHN_A = VALUE_W'(FHN_A_L);
	localparam logic signed [VALUE_W-1:0] FHN_B = VALUE_W'(FHN_B_L);

	// Reciprocals for division by 3 and by 12.5 (2/25), each followed by one correction.
	localparam int RECIP3_SH  = 33;
	localparam int RECIP25_SH = 35;
	localparam logic [VALUE_W-1:0] RECIP3  = VALUE_W'((longint'(1) << RECIP3_SH) / 3);
	localparam logic [VALUE_W-1:0] RECIP25 = VALUE_W'((longint'(1) << (RECIP25_SH + 1)) / 25);

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int MODE_W     = 2;
	localparam int THRESH_W   = 31;
	localparam int GAIN_W     = 31;
	localparam int RATE_W     = 25;
	localparam int REFR_W     = 16;

	localparam logic [CFG_IDX_W-1:0] REG_MODEL  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEAK   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STEP   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_REFR   = 3'd5;

	localparam logic [MODE_W-1:0]   RST_MODEL  = 2'd0;
	localparam logic [THRESH_W-1:0] RST_THRESH = 31'd83886080;
	localparam logic [GAIN_W-1:0]   RST_GAIN   = 31'd16777216;
	localparam logic [RATE_W-1:0]   RST_LEAK   = 25'd167772;
	localparam logic [RATE_W-1:0]   RST_STEP   = 25'd5033165;
	localparam logic [REFR_W-1:0]   RST_REFR   = 16'd4410;

	// Model codes.
	localparam logic [MODE_W-1:0] MODE_IF  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LIF = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FHN = 2'd2;

	// Multiplier operand selections.
	localparam int MUL_OP_W = 4;
	localparam logic [MUL_OP_W-1:0] MUL_NONE = 4'd0;
	localparam logic [MUL_OP_W-1:0] MUL_GI   = 4'd1;
	localparam logic [MUL_OP_W-1:0] MUL_KV   = 4'd2;
	localparam logic [MUL_OP_W-1:0] MUL_VV   = 4'd3;
	localparam logic [MUL_OP_W-1:0] MUL_TV   = 4'd4;
	localparam logic [MUL_OP_W-1:0] MUL_HT   = 4'd5;
	localparam logic [MUL_OP_W-1:0] MUL_BW   = 4'd6;
	localparam logic [MUL_OP_W-1:0] MUL_D3   = 4'd7;
	localparam logic [MUL_OP_W-1:0] MUL_D25  = 4'd8;

	// Post-multiply and register update operations.
	localparam int ALU_OP_W = 4;
	localparam logic [ALU_OP_W-1:0] ALU_NONE = 4'd0;
	localparam logic [ALU_OP_W-1:0] ALU_VADD = 4'd1;
	localparam logic [ALU_OP_W-1:0] ALU_UF   = 4'd2;
	localparam logic [ALU_OP_W-1:0] ALU_LG   = 4'd3;
	localparam logic [ALU_OP_W-1:0] ALU_VSUB = 4'd4;
	localparam logic [ALU_OP_W-1:0] ALU_TF   = 4'd5;
	localparam logic [ALU_OP_W-1:0] ALU_D3   = 4'd6;
	localparam logic [ALU_OP_W-1:0] ALU_DV1  = 4'd7;
	localparam logic [ALU_OP_W-1:0] ALU_DV2  = 4'd8;
	localparam logic [ALU_OP_W-1:0] ALU_DW   = 4'd9;
	localparam logic [ALU_OP_W-1:0] ALU_D25  = 4'd10;
	localparam logic [ALU_OP_W-1:0] ALU_WADD = 4'd11;
	localparam logic [ALU_OP_W-1:0] ALU_FIN  = 4'd12;

	// Controller to datapath command.
	typedef struct packed {
		logic                load_in;
		logic [MUL_OP_W-1:0] mul_op;
		logic [ALU_OP_W-1:0] alu_op;
	} sns_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic              held;
		logic [MODE_W-1:0] mode;
		logic              lif_small;
	} sns_stat_t;

endpackage

### src/spiking_neuron_step_core.sv
// Top level of the spiking neuron step core: controller, datapath and configuration port.
// Each accepted sample runs its model's multiply and update states, then a final state that
// registers the result and returns to idle for the next sample. Leaky integrate-and-fire adds
// a second leak only when 0 < v < threshold; held or unused-mode samples skip to the final state.
// One shared 32x32 multiplier, stepped one term at a time; a stalled result holds the final state.
// Reset is asynchronous: state clears, registers take defaults.
module spiking_neuron_step_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 sample_valid,
	output logic                                 sample_stall,
	input  logic signed [sns_pkg::VALUE_W-1:0]   input_current,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic signed [sns_pkg::VALUE_W-1:0]   membrane,
	output logic                                 spike,
	output logic                                 refractory,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [sns_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [sns_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import sns_pkg::*;

	sns_cmd_t  cmd;
	sns_stat_t stat;
	logic      cfg_we;

	// Register writes are taken in any cycle.
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	sns_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.stat         (stat),
		.cmd          (cmd)
	);

	sns_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.input_current (input_current),
		.membrane      (membrane),
		.spike         (spike),
		.refractory    (refractory)
	);

endmodule

### src/sns_dp.sv
// Datapath of the spiking neuron step core: state, configuration, shared multiplier and ALU.
module sns_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  sns_pkg::sns_cmd_t                    cmd,
	output sns_pkg::sns_stat_t                   stat,
	input  logic                                 cfg_we,
	input  logic [sns_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [sns_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic signed [sns_pkg::VALUE_W-1:0]   input_current,
	output logic signed [sns_pkg::VALUE_W-1:0]   membrane,
	output logic                                 spike,
	output logic                                 refractory
);
	import sns_pkg::*;

	localparam logic [MAG_W-1:0] POS_LIM = MAG_W'(VMAX);
	localparam logic [MAG_W-1:0] NEG_LIM = POS_LIM + 1'b1;
	localparam int EXT_W = VALUE_W + 2;

	function automatic logic signed [VALUE_W-1:0] sat_add(
		input logic signed [VALUE_W-1:0] a,
		input logic signed [VALUE_W-1:0] b
	);
		logic signed [VALUE_W:0] s;
		s = {a[VALUE_W-1], a} + {b[VALUE_W-1], b};
		if (s[VALUE_W] != s[VALUE_W-1]) begin
			return s[VALUE_W] ? VMIN : VMAX;
		end
		return s[VALUE_W-1:0];
	endfunction

	function automatic logic signed [VALUE_W-1:0] sat_sub(
		input logic signed [VALUE_W-1:0] a,
		input logic signed [VALUE_W-1:0] b
	);
		logic signed [VALUE_W:0] s;
		s = {a[VALUE_W-1], a} - {b[VALUE_W-1], b};
		if (s[VALUE_W] != s[VALUE_W-1]) begin
			return s[VALUE_W] ? VMIN : VMAX;
		end
		return s[VALUE_W-1:0];
	endfunction

	function automatic logic [VALUE_W-1:0] mag_of(input logic signed [VALUE_W-1:0] a);
		return a[VALUE_W-1] ? ((~a) + 1'b1) : a;
	endfunction

	// State and configuration registers.
	logic signed [VALUE_W-1:0] v_q, w_q;
	logic [REFR_W-1:0]         refr_left_q;
	logic [MODE_W-1:0]         model_q;
	logic [THRESH_W-1:0]       thresh_q;
	logic [GAIN_W-1:0]         gain_q;
	logic [RATE_W-1:0]         leak_q;
	logic [RATE_W-1:0]         step_q;
	logic [REFR_W-1:0]         refr_len_q;

	// Working registers.
	logic signed [VALUE_W-1:0] cur_q, t_q, u_q;
	logic [PROD_W-1:0]         prod_q;
	logic                      neg_q;
	logic signed [VALUE_W-1:0] membrane_q;
	logic                      spike_q, refractory_q;

	logic [VALUE_W-1:0]        mul_a, mul_b, t_mag;
	logic                      mul_neg;
	logic [MAG_W-1:0]          f_mag;
	logic signed [VALUE_W-1:0] f_val, d3_val, d25_val;
	logic [VALUE_W-1:0]        q3_0, q3, q25_0, q25;
	logic [EXT_W-1:0]          q3_ext, r3, q25_ext, r25;
	logic signed [VALUE_W-1:0] thresh_s;
	logic                      fin_clear, fin_spike, fin_refr;
	logic signed [VALUE_W-1:0] fin_mem;
	logic [REFR_W-1:0]         fin_left;

	assign t_mag    = mag_of(t_q);
	assign thresh_s = $signed({1'b0, thresh_q});

	// Multiplier operand selection: magnitudes and result sign.
	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		mul_neg = 1'b0;
		case (cmd.mul_op)
			MUL_GI: begin
				mul_a   = VALUE_W'(gain_q);
				mul_b   = mag_of(cur_q);
				mul_neg = cur_q[VALUE_W-1];
			end
			MUL_KV: begin
				mul_a   = VALUE_W'(leak_q);
				mul_b   = mag_of(v_q);
				mul_neg = v_q[VALUE_W-1];
			end
			MUL_VV: begin
				mul_a   = mag_of(v_q);
				mul_b   = mag_of(v_q);
			end
			MUL_TV: begin
				mul_a   = t_mag;
				mul_b   = mag_of(v_q);
				mul_neg = t_q[VALUE_W-1] ^ v_q[VALUE_W-1];
			end
			MUL_HT: begin
				mul_a   = VALUE_W'(step_q);
				mul_b   = t_mag;
				mul_neg = t_q[VALUE_W-1];
			end
			MUL_BW: begin
				mul_a   = VALUE_W'(FHN_B);
				mul_b   = mag_of(w_q);
				mul_neg = w_q[VALUE_W-1];
			end
			MUL_D3: begin
				mul_a   = t_mag;
				mul_b   = RECIP3;
				mul_neg = t_q[VALUE_W-1];
			end
			MUL_D25: begin
				mul_a   = t_mag;
				mul_b   = RECIP25;
				mul_neg = t_q[VALUE_W-1];
			end
			default: ;
		endcase
	end

	// Fixed-point product: drop the fraction, saturate, apply the sign.
	always_comb begin
		f_mag = prod_q[PROD_W-1:FRAC_W];
		if (!neg_q) begin
			f_val = (f_mag > POS_LIM) ? VMAX : $signed(f_mag[VALUE_W-1:0]);
		end else begin
			f_val = (f_mag > NEG_LIM) ? VMIN : $signed((~f_mag[VALUE_W-1:0]) + 1'b1);
		end
	end

	// Division by 3 toward zero: reciprocal estimate plus one correction step.
	always_comb begin
		q3_0   = VALUE_W'(prod_q[PROD_W-1:RECIP3_SH]);
		q3_ext = EXT_W'(q3_0);
		r3     = EXT_W'(t_mag) - ((q3_ext << 1) + q3_ext);
		q3     = (r3 >= EXT_W'(3)) ? (q3_0 + 1'b1) : q3_0;
		d3_val = neg_q ? $signed((~q3) + 1'b1) : $signed(q3);
	end

	// Doubling then division by 25 toward zero, same scheme.
	always_comb begin
		q25_0   = VALUE_W'(prod_q[PROD_W-1:RECIP25_SH]);
		q25_ext = EXT_W'(q25_0);
		r25     = (EXT_W'(t_mag) << 1) - ((q25_ext << 4) + (q25_ext << 3) + q25_ext);
		q25     = (r25 >= EXT_W'(25)) ? (q25_0 + 1'b1) : q25_0;
		d25_val = neg_q ? $signed((~q25) + 1'b1) : $signed(q25);
	end

	// End of step: refractory countdown, threshold test and result values.
	always_comb begin
		fin_clear = 1'b0;
		fin_spike = 1'b0;
		fin_refr  = 1'b0;
		fin_mem   = v_q;
		fin_left  = refr_left_q;
		if (refr_left_q != '0) begin
			fin_left = refr_left_q - 1'b1;
			fin_refr = 1'b1;
			if (refr_left_q == REFR_W'(1)) begin
				fin_clear = 1'b1;
				fin_mem   = '0;
			end
		end else if (v_q > thresh_s) begin
			fin_spike = 1'b1;
			fin_left  = refr_len_q;
			if (refr_len_q == '0) begin
				fin_clear = 1'b1;
				fin_mem   = '0;
			end else begin
				fin_refr  = 1'b1;
			end
		end
	end

	// Neuron state and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q         <= '0;
			w_q         <= '0;
			refr_left_q <= '0;
			model_q     <= RST_MODEL;
			thresh_q    <= RST_THRESH;
			gain_q      <= RST_GAIN;
			leak_q      <= RST_LEAK;
			step_q      <= RST_STEP;
			refr_len_q  <= RST_REFR;
		end else begin
			case (cmd.alu_op)
				ALU_VADD: v_q <= sat_add(v_q, f_val);
				ALU_LG:   v_q <= sat_sub(sat_add(v_q, f_val), u_q);
				ALU_VSUB: v_q <= sat_sub(v_q, f_val);
				ALU_WADD: w_q <= sat_add(w_q, t_q);
				ALU_FIN: begin
					refr_left_q <= fin_left;
					if (fin_clear) begin
						v_q <= '0;
						w_q <= '0;
					end
				end
				default: ;
			endcase
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MODEL: begin
						model_q <= cfg_data[MODE_W-1:0];
						v_q     <= '0;
						w_q     <= '0;
					end
					REG_THRESH: thresh_q   <= cfg_data[THRESH_W-1:0];
					REG_GAIN:   gain_q     <= cfg_data[GAIN_W-1:0];
					REG_LEAK:   leak_q     <= cfg_data[RATE_W-1:0];
					REG_STEP:   step_q     <= cfg_data[RATE_W-1:0];
					REG_REFR:   refr_len_q <= cfg_data[REFR_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// Working registers, product register and result register.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cur_q <= input_current;
		end
		if (cmd.mul_op != MUL_NONE) begin
			prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
			neg_q  <= mul_neg;
		end
		case (cmd.alu_op)
			ALU_UF:  u_q <= f_val;
			ALU_TF:  t_q <= f_val;
			ALU_D3:  t_q <= d3_val;
			ALU_DV1: t_q <= sat_sub(sat_sub(v_q, t_q), w_q);
			ALU_DV2: t_q <= sat_add(t_q, cur_q);
			ALU_DW:  t_q <= sat_sub(sat_sub(v_q, FHN_A), u_q);
			ALU_D25: t_q <= d25_val;
			ALU_FIN: begin
				membrane_q   <= fin_mem;
				spike_q      <= fin_spike;
				refractory_q <= fin_refr;
			end
			default: ;
		endcase
	end

	assign membrane   = membrane_q;
	assign spike      = spike_q;
	assign refractory = refractory_q;

	assign stat.held      = (refr_left_q != '0);
	assign stat.mode      = model_q;
	assign stat.lif_small = (v_q > 0) && (v_q < thresh_s);

`ifndef SYNTHESIS
	// A held sample must not run any model update.
	a_held_no_update: assert property (@(posedge clk) disable iff (!arst_n)
		(refr_left_q != '0) |-> (cmd.alu_op == ALU_NONE || cmd.alu_op == ALU_FIN))
		else $error("model update issued while refractory");

	// The refractory count moves only at the end of a step.
	a_refr_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.alu_op != ALU_FIN) |=> $stable(refr_left_q))
		else $error("refractory count changed outside step end");

	// The model selection changes only through a configuration transfer.
	a_model_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_we |=> $stable(model_q))
		else $error("model selection changed without a write");
`endif

endmodule

### src/sns_ctrl.sv
// Controller of the spiking neuron step core: sequences multiplier and ALU steps per sample.
module sns_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_stall,
	output logic               result_valid,
	input  logic               result_stall,
	input  sns_pkg::sns_stat_t stat,
	output sns_pkg::sns_cmd_t  cmd
);
	import sns_pkg::*;

	localparam int ST_W = 5;
	localparam logic [ST_W-1:0] ST_IDLE      = 5'd0;
	localparam logic [ST_W-1:0] ST_IF_M      = 5'd1;
	localparam logic [ST_W-1:0] ST_IF_A      = 5'd2;
	localparam logic [ST_W-1:0] ST_LK1_M     = 5'd3;
	localparam logic [ST_W-1:0] ST_LK1_A     = 5'd4;
	localparam logic [ST_W-1:0] ST_LG_M      = 5'd5;
	localparam logic [ST_W-1:0] ST_LG_A      = 5'd6;
	localparam logic [ST_W-1:0] ST_LK2_M     = 5'd7;
	localparam logic [ST_W-1:0] ST_LK2_A     = 5'd8;
	localparam logic [ST_W-1:0] ST_FN_VV_M   = 5'd9;
	localparam logic [ST_W-1:0] ST_FN_VV_A   = 5'd10;
	localparam logic [ST_W-1:0] ST_FN_TV_M   = 5'd11;
	localparam logic [ST_W-1:0] ST_FN_TV_A   = 5'd12;
	localparam logic [ST_W-1:0] ST_FN_D3_M   = 5'd13;
	localparam logic [ST_W-1:0] ST_FN_D3_A   = 5'd14;
	localparam logic [ST_W-1:0] ST_FN_DV1    = 5'd15;
	localparam logic [ST_W-1:0] ST_FN_DV2    = 5'd16;
	localparam logic [ST_W-1:0] ST_FN_HV_M   = 5'd17;
	localparam logic [ST_W-1:0] ST_FN_HV_A   = 5'd18;
	localparam logic [ST_W-1:0] ST_FN_BW_M   = 5'd19;
	localparam logic [ST_W-1:0] ST_FN_BW_A   = 5'd20;
	localparam logic [ST_W-1:0] ST_FN_DW     = 5'd21;
	localparam logic [ST_W-1:0] ST_FN_HW_M   = 5'd22;
	localparam logic [ST_W-1:0] ST_FN_HW_A   = 5'd23;
	localparam logic [ST_W-1:0] ST_FN_D25_M  = 5'd24;
	localparam logic [ST_W-1:0] ST_FN_D25_A  = 5'd25;
	localparam logic [ST_W-1:0] ST_FN_WADD   = 5'd26;
	localparam logic [ST_W-1:0] ST_FIN       = 5'd27;

	logic [ST_W-1:0] state_q, state_d;
	logic            result_valid_q;
	logic            out_free;

	assign out_free = !result_valid_q || !result_stall;

	// Next state and command decode.
	always_comb begin
		cmd          = '0;
		state_d      = state_q;
		sample_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				sample_stall = 1'b0;
				if (sample_valid) begin
					cmd.load_in = 1'b1;
					if (stat.held) begin
						state_d = ST_FIN;
					end else begin
						unique case (stat.mode)
							MODE_IF:  state_d = ST_IF_M;
							MODE_LIF: state_d = ST_LK1_M;
							MODE_FHN: state_d = ST_FN_VV_M;
							default:  state_d = ST_FIN;
						endcase
					end
				end
			end
			// Integrate-and-fire.
			ST_IF_M: begin
				cmd.mul_op = MUL_GI;
				state_d    = ST_IF_A;
			end
			ST_IF_A: begin
				cmd.alu_op = ALU_VADD;
				state_d    = ST_FIN;
			end
			// Leaky integrate-and-fire.
			ST_LK1_M: begin
				cmd.mul_op = MUL_KV;
				state_d    = ST_LK1_A;
			end
			ST_LK1_A: begin
				cmd.alu_op = ALU_UF;
				state_d    = ST_LG_M;
			end
			ST_LG_M: begin
				cmd.mul_op = MUL_GI;
				state_d    = ST_LG_A;
			end
			ST_LG_A: begin
				cmd.alu_op = ALU_LG;
				state_d    = ST_LK2_M;
			end
			ST_LK2_M: begin
				cmd.mul_op = MUL_KV;
				state_d    = stat.lif_small ? ST_LK2_A : ST_FIN;
			end
			ST_LK2_A: begin
				cmd.alu_op = ALU_VSUB;
				state_d    = ST_FIN;
			end
			// FitzHugh-Nagumo: cubic term first.
			ST_FN_VV_M: begin
				cmd.mul_op = MUL_VV;
				state_d    = ST_FN_VV_A;
			end
			ST_FN_VV_A: begin
				cmd.alu_op = ALU_TF;
				state_d    = ST_FN_TV_M;
			end
			ST_FN_TV_M: begin
				cmd.mul_op = MUL_TV;
				state_d    = ST_FN_TV_A;
			end
			ST_FN_TV_A: begin
				cmd.alu_op = ALU_TF;
				state_d    = ST_FN_D3_M;
			end
			ST_FN_D3_M: begin
				cmd.mul_op = MUL_D3;
				state_d    = ST_FN_D3_A;
			end
			ST_FN_D3_A: begin
				cmd.alu_op = ALU_D3;
				state_d    = ST_FN_DV1;
			end
			ST_FN_DV1: begin
				cmd.alu_op = ALU_DV1;
				state_d    = ST_FN_DV2;
			end
			ST_FN_DV2: begin
				cmd.alu_op = ALU_DV2;
				state_d    = ST_FN_HV_M;
			end
			// Potential step, then the recovery step from the new potential.
			ST_FN_HV_M: begin
				cmd.mul_op = MUL_HT;
				state_d    = ST_FN_HV_A;
			end
			ST_FN_HV_A: begin
				cmd.alu_op = ALU_VADD;
				state_d    = ST_FN_BW_M;
			end
			ST_FN_BW_M: begin
				cmd.mul_op = MUL_BW;
				state_d    = ST_FN_BW_A;
			end
			ST_FN_BW_A: begin
				cmd.alu_op = ALU_UF;
				state_d    = ST_FN_DW;
			end
			ST_FN_DW: begin
				cmd.alu_op = ALU_DW;
				state_d    = ST_FN_HW_M;
			end
			ST_FN_HW_M: begin
				cmd.mul_op = MUL_HT;
				state_d    = ST_FN_HW_A;
			end
			ST_FN_HW_A: begin
				cmd.alu_op = ALU_TF;
				state_d    = ST_FN_D25_M;
			end
			ST_FN_D25_M: begin
				cmd.mul_op = MUL_D25;
				state_d    = ST_FN_D25_A;
			end
			ST_FN_D25_A: begin
				cmd.alu_op = ALU_D25;
				state_d    = ST_FN_WADD;
			end
			ST_FN_WADD: begin
				cmd.alu_op = ALU_WADD;
				state_d    = ST_FIN;
			end
			// Close the step once the result register can take it.
			ST_FIN: begin
				if (out_free) begin
					cmd.alu_op = ALU_FIN;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State register and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.alu_op == ALU_FIN) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = result_valid_q;

`ifndef SYNTHESIS
	// A waiting result is never dropped.
	a_result_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_stall) |=> result_valid_q)
		else $error("stalled result was lost");

	// An accepted sample always leaves the idle state.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_in |=> (state_q != ST_IDLE))
		else $error("accepted sample not processed");

	// Samples are taken only while the controller is idle.
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall == (state_q != ST_IDLE))
		else $error("sample stall out of step with the controller");
`endif

endmodule

### tb/spiking_neuron_step_core_test.sv
// Testbench for the spiking neuron step core: random and directed samples checked by a scoreboard.
module spiking_neuron_step_core_test;
	import sns_pkg::*;

	localparam longint VAL_MAX = (longint'(1) << (VALUE_W - 1)) - 1;
	localparam longint VAL_MIN = -VAL_MAX - 1;
	localparam int ONE = 1 << FRAC_W;
	localparam int QUIET_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 30;
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_SAMPLES = 100;
	localparam int MAX_PRINTED = 40;

	// Indexes the block has no register for, and the mode code with no dynamics.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	typedef logic signed [VALUE_W-1:0] value_t;

	typedef struct {
		value_t membrane;
		logic   spike;
		logic   refractory;
	} neuron_step_t;

	// Tracks the neuron state and its settings, predicts each step and checks the outputs.
	class neuron_scoreboard;
		longint            potential;
		longint            recovery;
		int unsigned       refr_left;
		logic [MODE_W-1:0] model;
		longint            threshold;
		longint            gain;
		longint            leak;
		longint            step_h;
		int unsigned       refr_len;
		neuron_step_t      predicted_steps[$];
		int                errors;

		function new();
			potential = 0;
			recovery = 0;
			refr_left = 0;
			model = RST_MODEL;
			threshold = RST_THRESH;
			gain = RST_GAIN;
			leak = RST_LEAK;
			step_h = RST_STEP;
			refr_len = RST_REFR;
			errors = 0;
		endfunction

		function longint clamp(longint x);
			if (x > VAL_MAX) return VAL_MAX;
			if (x < VAL_MIN) return VAL_MIN;
			return x;
		endfunction

		// Fixed-point product, truncated toward zero and saturated.
		function longint qmul(longint a, longint b);
			logic neg;
			longint unsigned ua, ub, mag;
			neg = (a < 0) != (b < 0);
			ua = (a < 0) ? -a : a;
			ub = (b < 0) ? -b : b;
			mag = (ua * ub) >> FRAC_W;
			if (!neg && mag > VAL_MAX) return VAL_MAX;
			if (neg && mag > VAL_MAX + 1) return VAL_MIN;
			return neg ? -longint'(mag) : longint'(mag);
		endfunction

		function void report(string msg);
			if (errors < MAX_PRINTED)
				$display("mismatch: %s", msg);
			errors++;
		endfunction

		function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
			REG_MODEL: begin
				model = data[MODE_W-1:0];
				potential = 0;
				recovery = 0;
			end
			REG_THRESH: threshold = data[THRESH_W-1:0];
			REG_GAIN:   gain = data[GAIN_W-1:0];
			REG_LEAK:   leak = data[RATE_W-1:0];
			REG_STEP:   step_h = data[RATE_W-1:0];
			REG_REFR:   refr_len = data[REFR_W-1:0];
			default: ;
			endcase
		endfunction

		// One accepted sample: advance the neuron and queue the predicted outputs.
		function void note_sample(value_t cur_in);
			longint cur, v, kv, cube, dv, dw;
			neuron_step_t s;
			cur = cur_in;
			s.spike = 1'b0;
			s.refractory = 1'b0;
			if (refr_left != 0) begin
				// Refractory samples are ignored; the last one clears the state.
				refr_left--;
				if (refr_left == 0) begin
					potential = 0;
					recovery = 0;
				end
				s.refractory = 1'b1;
			end else begin
				v = potential;
				case (model)
				MODE_IF: begin
					v = clamp(v + qmul(gain, cur));
				end
				MODE_LIF: begin
					kv = qmul(leak, v);
					v = clamp(clamp(v + qmul(gain, cur)) - kv);
					if (v > 0 && v < threshold)
						v = clamp(v - qmul(leak, v));
				end
				MODE_FHN: begin
					cube = qmul(qmul(v, v), v) / 3;
					dv = clamp(clamp(clamp(v - cube) - recovery) + cur);
					v = clamp(v + qmul(step_h, dv));
					dw = clamp(clamp(v - FHN_A_L) - qmul(FHN_B_L, recovery));
					dw = (qmul(step_h, dw) * 2) / 25;
					recovery = clamp(recovery + dw);
				end
				default: ;
				endcase
				potential = v;
				if (potential > threshold) begin
					s.spike = 1'b1;
					refr_left = refr_len;
					if (refr_len == 0) begin
						potential = 0;
						recovery = 0;
					end
					s.refractory = (refr_left != 0);
				end
			end
			s.membrane = value_t'(potential);
			predicted_steps.push_back(s);
		endfunction

		function void check_result(value_t m, logic sp, logic rf);
			neuron_step_t s;
			if (predicted_steps.size() == 0) begin
				report($sformatf("result with no prediction waiting: membrane %0d", m));
				return;
			end
			s = predicted_steps.pop_front();
			if (m !== s.membrane)
				report($sformatf("membrane %0d, predicted %0d", m, s.membrane));
			if (sp !== s.spike)
				report($sformatf("spike %b, predicted %b", sp, s.spike));
			if (rf !== s.refractory)
				report($sformatf("refractory %b, predicted %b", rf, s.refractory));
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  sample_valid = 1'b0;
	logic                  sample_stall;
	value_t                input_current = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	value_t                membrane;
	logic                  spike;
	logic                  refractory;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_requests = 0;
	int holds_served = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	neuron_scoreboard sb = new;

	spiking_neuron_step_core dut (.*);

	always #5 clk = ~clk;

	// Result side: check each transfer, then choose the stall for the next cycle.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result(membrane, spike, refractory);
		if (hold_requests != holds_served) begin
			holds_served <= hold_requests;
			hold_left <= HOLD_CYCLES;
			result_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Watchdog: end the run when no transfer of any kind happens for too long.
	always @(posedge clk) begin
		if (!arst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("spiking_neuron_step_core_test: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one sample, with random idle cycles ahead of it, and wait for its transfer.
	task automatic send_sample(value_t cur);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		input_current <= cur;
		@(posedge clk);
		while (sample_stall) @(posedge clk);
		sb.note_sample(cur);
	endtask

	// Register write; bits above the field width carry random garbage.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value, int width);
		logic [CFG_DATA_W-1:0] data;
		data = ($urandom() << width) | value;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.note_config(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Stop offering samples and wait until the block has delivered everything.
	task automatic settle();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (sb.predicted_steps.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Random settings for one phase, with two phases pinned to the extremes.
	task automatic configure_phase(int phase);
		logic [MODE_W-1:0] mode;
		logic [31:0]       thr, gain_v, leak_v, step_v;
		logic [15:0]       refr;
		int                pick;
		pick = $urandom_range(9);
		mode = (pick < 3) ? MODE_IF : (pick < 6) ? MODE_LIF : (pick < 9) ? MODE_FHN : MODE_UNUSED;
		pick = $urandom_range(5);
		thr = (pick == 0) ? 32'd0 : (pick == 1) ? 32'(VAL_MAX) : (pick == 2) ? $urandom() >> 1 :
			$urandom_range(8 << FRAC_W, 1 << 20);
		pick = $urandom_range(5);
		gain_v = (pick == 0) ? 32'd0 : (pick == 1) ? 32'(VAL_MAX) : (pick == 2) ? $urandom() >> 1 :
			$urandom_range(4 << FRAC_W, 1 << 18);
		pick = $urandom_range(4);
		leak_v = (pick == 0) ? 32'd0 : (pick == 1) ? 32'(ONE) : $urandom_range(ONE, 0);
		pick = $urandom_range(4);
		step_v = (pick == 0) ? 32'd0 : (pick == 1) ? 32'(ONE) : $urandom_range(ONE, 0);
		refr = ($urandom_range(3) == 0) ? 16'($urandom_range(40, 10)) : 16'($urandom_range(6, 0));
		if (phase == 2) begin
			thr = 32'(VAL_MAX);
			gain_v = 32'(VAL_MAX);
			leak_v = 32'(ONE);
			step_v = 32'(ONE);
			refr = 16'hFFFF;
		end else if (phase == 5) begin
			thr = '0;
			leak_v = '0;
			step_v = '0;
			refr = '0;
		end
		write_reg(REG_THRESH, thr, THRESH_W);
		write_reg(REG_GAIN, gain_v, GAIN_W);
		write_reg(REG_LEAK, leak_v, RATE_W);
		write_reg(REG_STEP, step_v, RATE_W);
		write_reg(REG_REFR, CFG_DATA_W'(refr), REFR_W);
		write_reg(REG_MODEL, CFG_DATA_W'(mode), MODE_W);
	endtask

	// Mostly modest currents biased upward so the neuron integrates to threshold.
	function automatic value_t random_current();
		int unsigned span;
		int          pick;
		pick = $urandom_range(9);
		span = 1 << $urandom_range(28, 14);
		if (pick < 2)
			return $urandom();
		if (pick == 2)
			return ($urandom_range(1) == 0) ? VMIN : VMAX;
		if (pick == 3)
			return ($urandom_range(1) == 0) ? value_t'(0) : value_t'(-1);
		return value_t'($urandom_range(span, 0)) - value_t'(span / 3);
	endfunction

	initial begin
		int phase;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: integrate below the threshold and drive currents at both rails.
		send_sample(0);
		send_sample(ONE);
		send_sample(2 * ONE);
		send_sample(-3 * ONE);
		send_sample(VMIN);
		send_sample(VMAX);
		send_sample(1);

		// A spike followed by a short refractory stretch.
		settle();
		write_reg(REG_THRESH, ONE, THRESH_W);
		write_reg(REG_REFR, 3, REFR_W);
		send_sample(2 * ONE);
		send_sample(0);

		// Mode change in the middle of refractory, then the leaky model with full leak.
		settle();
		write_reg(REG_MODEL, CFG_DATA_W'(MODE_LIF), MODE_W);
		write_reg(REG_LEAK, ONE, RATE_W);
		send_sample(0);
		send_sample(0);
		send_sample(ONE / 2);
		send_sample(VMAX);
		repeat (3) send_sample(-ONE);

		// Spike with no refractory length clears at once.
		settle();
		write_reg(REG_REFR, 0, REFR_W);
		write_reg(REG_MODEL, CFG_DATA_W'(MODE_IF), MODE_W);
		send_sample(2 * ONE);

		// Unused mode holds the potential; writes to missing registers are dropped.
		settle();
		write_reg(REG_MODEL, CFG_DATA_W'(MODE_UNUSED), MODE_W);
		write_reg(REG_SPARE_LO, $urandom(), 0);
		write_reg(REG_SPARE_HI, $urandom(), 0);
		send_sample(ONE);
		send_sample(VMAX);

		// FitzHugh-Nagumo with a full step.
		settle();
		write_reg(REG_MODEL, CFG_DATA_W'(MODE_FHN), MODE_W);
		write_reg(REG_STEP, ONE, RATE_W);
		send_sample(ONE);
		send_sample(-ONE);
		send_sample(VMIN);
		send_sample(VMAX);

		// Random phases, each with fresh settings and an idling pattern set by its number.
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			settle();
			configure_phase(phase);
			send_idle_pct = (phase % 4 == 1) ? 56 : (phase % 4 == 3) ? 36 : 0;
			recv_idle_pct <= (phase % 4 == 2) ? 56 : (phase % 4 == 3) ? 36 : 0;
			if (phase == 4)
				hold_requests <= hold_requests + 1;
			repeat (PHASE_SAMPLES) send_sample(random_current());
		end

		settle();
		if (sb.errors == 0 && sb.predicted_steps.size() == 0)
			$display("spiking_neuron_step_core_test: PASS");
		else
			$display("spiking_neuron_step_core_test: FAIL");
		$finish;
	end

endmodule
